// ===== src/mp2d_pkg.sv =====
// Shared constants and types for the streaming 2-D max pooling block.
`default_nettype none
package mp2d_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_STRIDE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE     = 3'd4;

  // Register widths.
  localparam int ROWS_REG_W   = 9;
  localparam int COLS_REG_W   = 9;
  localparam int CHANS_REG_W  = 7;
  localparam int STRIDE_REG_W = 4;
  localparam int SIZE_REG_W   = 4;

  // Register reset values.
  localparam logic [ROWS_REG_W-1:0]   ROWS_RST   = 9'd16;
  localparam logic [COLS_REG_W-1:0]   COLS_RST   = 9'd16;
  localparam logic [CHANS_REG_W-1:0]  CHANS_RST  = 7'd1;
  localparam logic [STRIDE_REG_W-1:0] STRIDE_RST = 4'd2;
  localparam logic [SIZE_REG_W-1:0]   SIZE_RST   = 4'd2;

  // Result field widths.
  localparam int OUT_ROW_W = 8;
  localparam int OUT_COL_W = 8;
  localparam int OUT_CH_W  = 6;

  // Control of the running-maximum store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mp2d_mem_ctl_t;

endpackage
`default_nettype wire

// ===== src/max_pooling_2d_stream.sv =====
// Top level of the streaming 2-D max pooling block.
// An accepted sample passes stage registers s1, s2, s3 and then the output register.
// Throughput: one sample per cycle unless the output stalls; one read-modify-write
// of the running-maximum store per sample, forwarding on back-to-back hits.
// Reset clears the position counters, pipeline and output valids, and loads the
// register defaults; the maximum store is not cleared and needs no clearing pass.
`default_nettype none
module max_pooling_2d_stream #(
  parameter int MAX_MAP_ROWS = 256,
  parameter int MAX_MAP_COLS = 256,
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_POOL     = 8,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Sample channel.
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample,
  // Result channel.
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]             out_pooled_value,
  output logic [mp2d_pkg::OUT_ROW_W-1:0]            out_row,
  output logic [mp2d_pkg::OUT_COL_W-1:0]            out_col,
  output logic [mp2d_pkg::OUT_CH_W-1:0]             out_channel,
  output logic                                      out_frame_last,
  // Configuration channel.
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mp2d_pkg::*;

  localparam int RW     = (MAX_MAP_ROWS > 1) ? $clog2(MAX_MAP_ROWS) : 1;
  localparam int CW     = (MAX_MAP_COLS > 1) ? $clog2(MAX_MAP_COLS) : 1;
  localparam int HW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RLW    = $clog2(MAX_MAP_ROWS + 1);
  localparam int CLW    = $clog2(MAX_MAP_COLS + 1);
  localparam int HLW    = $clog2(MAX_CHANNELS + 1);
  localparam int PW     = $clog2(MAX_POOL + 1);
  localparam int ADDR_W = CW + HW;
  localparam int RPW    = RW + PW + 2;
  localparam int CPW    = CW + PW + 2;

  // Configuration registers.
  logic [ROWS_REG_W-1:0]   map_rows_r;
  logic [COLS_REG_W-1:0]   map_cols_r;
  logic [CHANS_REG_W-1:0]  channel_count_r;
  logic [STRIDE_REG_W-1:0] pool_stride_r;
  logic [SIZE_REG_W-1:0]   pool_size_r;

  // Clamped geometry.
  logic [RLW-1:0] rows_cl;
  logic [CLW-1:0] cols_cl;
  logic [HLW-1:0] chans_cl;
  logic [PW-1:0]  stride_cl;
  logic [PW-1:0]  size_cl;

  // Position counters.
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] ch_r, ch_nxt;

  logic adv;
  logic accept;

  // Pipeline stages.
  logic                          s1_valid_r;
  logic [HW-1:0]                 s1_ch_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s2_valid_r;
  logic [HW-1:0]                 s2_ch_r;
  logic signed [SAMPLE_BITS-1:0] s2_sample_r;
  logic                          s3_valid_r;
  logic                          s3_active_r;
  logic                          s3_start_r;
  logic                          s3_done_r;
  logic                          s3_last_r;
  logic signed [SAMPLE_BITS-1:0] s3_sample_r;
  logic [ADDR_W-1:0]             s3_addr_r;
  logic [RW-1:0]                 s3_row_r;
  logic [CW-1:0]                 s3_col_r;
  logic [HW-1:0]                 s3_ch_r;

  // Divider outputs.
  logic [RW-1:0] row_q;
  logic [PW-1:0] row_rem;
  logic [CW-1:0] col_q;
  logic [PW-1:0] col_rem;

  // Window decode.
  logic [RPW-1:0]    r_end1, r_end2;
  logic [CPW-1:0]    c_end1, c_end2;
  logic              in_row, in_col, last_row, last_col;
  logic              win_active, win_start, win_done, win_last;
  logic [ADDR_W-1:0] rd_addr;

  // Store and result.
  mp2d_mem_ctl_t                 mem_ctl;
  logic [SAMPLE_BITS-1:0]        old_max;
  logic signed [SAMPLE_BITS-1:0] old_max_s;
  logic signed [SAMPLE_BITS-1:0] new_max;
  logic                          emit;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_pooled_value_r;
  logic [OUT_ROW_W-1:0]          out_row_r;
  logic [OUT_COL_W-1:0]          out_col_r;
  logic [OUT_CH_W-1:0]           out_channel_r;
  logic                          out_frame_last_r;

  // Configuration writes; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_rows_r      <= ROWS_RST;
      map_cols_r      <= COLS_RST;
      channel_count_r <= CHANS_RST;
      pool_stride_r   <= STRIDE_RST;
      pool_size_r     <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAP_ROWS:      map_rows_r      <= cfg_data[ROWS_REG_W-1:0];
        CFG_MAP_COLS:      map_cols_r      <= cfg_data[COLS_REG_W-1:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[CHANS_REG_W-1:0];
        CFG_POOL_STRIDE:   pool_stride_r   <= cfg_data[STRIDE_REG_W-1:0];
        CFG_POOL_SIZE:     pool_size_r     <= cfg_data[SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their legal ranges; the window never exceeds the stride.
  always_comb begin
    if (map_rows_r == '0) rows_cl = RLW'(1);
    else if (int'(map_rows_r) > MAX_MAP_ROWS) rows_cl = RLW'(MAX_MAP_ROWS);
    else rows_cl = RLW'(map_rows_r);

    if (map_cols_r == '0) cols_cl = CLW'(1);
    else if (int'(map_cols_r) > MAX_MAP_COLS) cols_cl = CLW'(MAX_MAP_COLS);
    else cols_cl = CLW'(map_cols_r);

    if (channel_count_r == '0) chans_cl = HLW'(1);
    else if (int'(channel_count_r) > MAX_CHANNELS) chans_cl = HLW'(MAX_CHANNELS);
    else chans_cl = HLW'(channel_count_r);

    if (pool_stride_r == '0) stride_cl = PW'(1);
    else if (int'(pool_stride_r) > MAX_POOL) stride_cl = PW'(MAX_POOL);
    else stride_cl = PW'(pool_stride_r);

    if (pool_size_r == '0) size_cl = PW'(1);
    else if (int'(pool_size_r) > int'(stride_cl)) size_cl = stride_cl;
    else size_cl = PW'(pool_size_r);
  end

  // The whole pipeline moves whenever the output register can take a result.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // Position counters: channel fastest, then column, then row.
  always_comb begin
    ch_nxt  = ch_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if ((int'(ch_r) + 1) >= int'(chans_cl)) begin
        ch_nxt = '0;
        if ((int'(col_r) + 1) >= int'(cols_cl)) begin
          col_nxt = '0;
          if ((int'(row_r) + 1) >= int'(rows_cl)) begin
            row_nxt = '0;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end else begin
        ch_nxt = ch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      ch_r  <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // Split row and column into window origin and offset inside the window.
  mp2d_div #(.N(RW), .MAX_D(MAX_POOL)) u_row_div (
    .clk  (clk),
    .en   (adv),
    .n_in (row_r),
    .d_in (stride_cl),
    .q    (row_q),
    .rem  (row_rem)
  );

  mp2d_div #(.N(CW), .MAX_D(MAX_POOL)) u_col_div (
    .clk  (clk),
    .en   (adv),
    .n_in (col_r),
    .d_in (stride_cl),
    .q    (col_q),
    .rem  (col_rem)
  );

  // Valid bits of the first two stages, alongside the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch_r     <= ch_r;
      s1_sample_r <= in_sample;
      s2_ch_r     <= s1_ch_r;
      s2_sample_r <= s1_sample_r;
    end
  end

  // Decode: inside the trimmed map and window, first and last sample, last window.
  always_comb begin
    r_end1   = (RPW'(row_q) + RPW'(1)) * RPW'(stride_cl);
    r_end2   = r_end1 + RPW'(stride_cl);
    c_end1   = (CPW'(col_q) + CPW'(1)) * CPW'(stride_cl);
    c_end2   = c_end1 + CPW'(stride_cl);
    in_row   = r_end1 <= RPW'(rows_cl);
    in_col   = c_end1 <= CPW'(cols_cl);
    last_row = r_end2 > RPW'(rows_cl);
    last_col = c_end2 > CPW'(cols_cl);
    win_active = in_row && in_col && (HLW'(s2_ch_r) < chans_cl) &&
                 (row_rem < size_cl) && (col_rem < size_cl);
    win_start  = (row_rem == '0) && (col_rem == '0);
    win_done   = (row_rem == size_cl - 1'b1) && (col_rem == size_cl - 1'b1);
    win_last   = last_row && last_col && (HLW'(s2_ch_r) == chans_cl - 1'b1);
    rd_addr    = {col_q, s2_ch_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_active_r <= win_active;
      s3_start_r  <= win_start;
      s3_done_r   <= win_done;
      s3_last_r   <= win_last;
      s3_sample_r <= s2_sample_r;
      s3_addr_r   <= rd_addr;
      s3_row_r    <= row_q;
      s3_col_r    <= col_q;
      s3_ch_r     <= s2_ch_r;
    end
  end

  // Read-modify-write of the running maximum.
  assign mem_ctl.rd_en = adv;
  assign mem_ctl.wr_en = adv && s3_valid_r && s3_active_r;

  mp2d_store #(.ADDR_W(ADDR_W), .DATA_W(SAMPLE_BITS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (s3_addr_r),
    .wr_data (new_max),
    .rd_data (old_max)
  );

  // The first sample of a window replaces whatever the entry held.
  assign old_max_s = $signed(old_max);
  assign new_max   = (s3_start_r || (s3_sample_r > old_max_s)) ? s3_sample_r : old_max_s;
  assign emit      = s3_valid_r && s3_active_r && s3_done_r;

  // Output register.
  assign out_valid_nxt = adv ? emit : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_pooled_value_r <= new_max;
      out_row_r          <= OUT_ROW_W'(s3_row_r);
      out_col_r          <= OUT_COL_W'(s3_col_r);
      out_channel_r      <= OUT_CH_W'(s3_ch_r);
      out_frame_last_r   <= s3_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = out_pooled_value_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_channel      = out_channel_r;
  assign out_frame_last   = out_frame_last_r;

  // An accepted sample always enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted sample did not enter the pipeline");

  // A stalled last stage keeps its item and its store address.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !adv |=> s3_valid_r && $stable(s3_addr_r))
    else $error("last stage lost its item during a stall");

  // No result appears when nothing is in flight.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r && !s2_valid_r && !s3_valid_r && !out_valid_r |=> !out_valid_r)
    else $error("result appeared with an empty pipeline");

endmodule
`default_nettype wire

// ===== src/mp2d_div.sv =====
// Two-stage division of a counter by the pool stride using a reciprocal table.
`default_nettype none
module mp2d_div #(
  parameter int N     = 8,
  parameter int MAX_D = 8,
  localparam int PW   = $clog2(MAX_D + 1)
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [N-1:0]  n_in,
  input  wire logic [PW-1:0] d_in,
  output logic      [N-1:0]  q,
  output logic      [PW-1:0] rem
);
  import mp2d_pkg::*;

  localparam int PRW = 2 * N + 1;
  localparam int TAB = 2 ** PW;

  logic [N:0]     recip_tab [TAB];
  logic [N:0]     recip;
  logic [PRW-1:0] prod;
  logic [N-1:0]   n_r;
  logic [PW-1:0]  d_r;
  logic [N-1:0]   q0_r;
  logic [N+PW-1:0] qd;
  logic [N-1:0]   rem0;
  logic           fix;
  logic [N-1:0]   q_r;
  logic [PW-1:0]  rem_r;

  // Reciprocals floor(2^N / d), worked out at elaboration.
  for (genvar g = 0; g < TAB; g++) begin : g_recip
    if (g >= 1 && g <= MAX_D) begin : g_used
      localparam longint unsigned RV = (longint'(1) << N) / g;
      assign recip_tab[g] = (N+1)'(RV);
    end else begin : g_unused
      assign recip_tab[g] = '0;
    end
  end

  // First stage: estimate the quotient, low by at most one.
  assign recip = recip_tab[d_in];
  assign prod  = PRW'(n_in) * PRW'(recip);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= n_in;
      d_r  <= d_in;
      q0_r <= prod[2*N-1:N];
    end
  end

  // Second stage: one compare and subtract corrects the estimate.
  assign qd   = (N+PW)'(q0_r) * (N+PW)'(d_r);
  assign rem0 = n_r - qd[N-1:0];
  assign fix  = rem0 >= N'(d_r);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= fix ? q0_r + 1'b1 : q0_r;
      rem_r <= fix ? PW'(rem0 - N'(d_r)) : PW'(rem0);
    end
  end

  assign q   = q_r;
  assign rem = rem_r;

endmodule
`default_nettype wire

// ===== src/mp2d_store.sv =====
// Running-maximum store: one write and one registered read per cycle with forwarding.
`default_nettype none
module mp2d_store #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mp2d_pkg::mp2d_mem_ctl_t ctl,
  input  wire logic [ADDR_W-1:0]       rd_addr,
  input  wire logic [ADDR_W-1:0]       wr_addr,
  input  wire logic [DATA_W-1:0]       wr_data,
  output logic      [DATA_W-1:0]       rd_data
);
  import mp2d_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_r;

  // Memory array: write port and registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // A read that meets a write to the same entry takes the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (ctl.rd_en) begin
      fwd_r <= ctl.wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the streaming 2-D max pooling block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int ITEM_TARGET  = 1650;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 400;
  // Indexes five to seven address no register.
  localparam logic [mp2d_pkg::CFG_IDX_W-1:0] CFG_UNUSED_BASE = 3'd5;

  // One expected window result.
  typedef struct {
    logic signed [15:0] value;
    logic [7:0]         row;
    logic [7:0]         col;
    logic [5:0]         chan;
    logic               last;
  } window_result_t;

  // Tracks the pooling position and running maxima, and holds the window
  // results still owed by the block.
  class maxpool_checker;
    localparam int MAP_LIMIT     = 256;
    localparam int CHANNEL_SLOTS = 64;
    localparam int POOL_LIMIT    = 8;

    logic [8:0] map_rows_q, map_cols_q;
    logic [6:0] chans_q;
    logic [3:0] stride_q, size_q;
    int eff_rows, eff_cols, eff_chans, eff_stride, eff_size, lim_r, lim_c;
    int row_pos, col_pos, chan_pos;
    logic signed [15:0] window_max [MAP_LIMIT * CHANNEL_SLOTS];
    window_result_t expected_windows [$];
    int errors, windows_checked, samples_taken;

    function new();
      map_rows_q = mp2d_pkg::ROWS_RST;
      map_cols_q = mp2d_pkg::COLS_RST;
      chans_q    = mp2d_pkg::CHANS_RST;
      stride_q   = mp2d_pkg::STRIDE_RST;
      size_q     = mp2d_pkg::SIZE_RST;
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
      errors = 0;
      windows_checked = 0;
      samples_taken = 0;
      refresh_geometry();
    endfunction

    function int clamp_to(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Saturate the registers and trim the map to whole strides.
    function void refresh_geometry();
      eff_rows   = clamp_to(int'(map_rows_q), 1, MAP_LIMIT);
      eff_cols   = clamp_to(int'(map_cols_q), 1, MAP_LIMIT);
      eff_chans  = clamp_to(int'(chans_q), 1, CHANNEL_SLOTS);
      eff_stride = clamp_to(int'(stride_q), 1, POOL_LIMIT);
      eff_size   = clamp_to(int'(size_q), 1, eff_stride);
      lim_r = eff_rows - eff_rows % eff_stride;
      lim_c = eff_cols - eff_cols % eff_stride;
    endfunction

    function void apply_write(logic [2:0] idx, logic [8:0] data);
      case (idx)
        mp2d_pkg::CFG_MAP_ROWS:      map_rows_q = data;
        mp2d_pkg::CFG_MAP_COLS:      map_cols_q = data;
        mp2d_pkg::CFG_CHANNEL_COUNT: chans_q = data[6:0];
        mp2d_pkg::CFG_POOL_STRIDE:   stride_q = data[3:0];
        mp2d_pkg::CFG_POOL_SIZE:     size_q = data[3:0];
        default: ;
      endcase
      refresh_geometry();
    endfunction

    function int frame_items();
      return eff_rows * eff_cols * eff_chans;
    endfunction

    // Fold one accepted sample into its window and note a completed window.
    function void take_sample(logic signed [15:0] s);
      int kr, kc, oc, orow, idx;
      logic signed [15:0] m;
      window_result_t w;
      samples_taken++;
      if (row_pos < lim_r && col_pos < lim_c && chan_pos < eff_chans) begin
        kr = row_pos % eff_stride;
        kc = col_pos % eff_stride;
        oc = col_pos / eff_stride;
        orow = row_pos / eff_stride;
        idx = oc * CHANNEL_SLOTS + chan_pos;
        if (kr < eff_size && kc < eff_size) begin
          // The window origin loads the store; later samples keep the larger.
          if ((kr == 0 && kc == 0) || (s > window_max[idx])) begin
            m = s;
          end else begin
            m = window_max[idx];
          end
          window_max[idx] = m;
          if (kr == eff_size - 1 && kc == eff_size - 1) begin
            w.value = m;
            w.row = 8'(orow);
            w.col = 8'(oc);
            w.chan = 6'(chan_pos);
            w.last = (orow == lim_r / eff_stride - 1) && (oc == lim_c / eff_stride - 1) &&
                     (chan_pos == eff_chans - 1);
            expected_windows.push_back(w);
          end
        end
      end
      // Channel runs fastest, then column, then row.
      chan_pos++;
      if (chan_pos >= eff_chans) begin
        chan_pos = 0;
        col_pos++;
        if (col_pos >= eff_cols) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= eff_rows) begin
            row_pos = 0;
          end
        end
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_window(logic signed [15:0] value, logic [7:0] row, logic [7:0] col,
                      logic [5:0] chan, logic last);
      window_result_t want;
      if (expected_windows.size() == 0) begin
        report($sformatf("result with none pending: value %0d row %0d col %0d ch %0d",
                         value, row, col, chan));
        return;
      end
      want = expected_windows.pop_front();
      windows_checked++;
      if (value !== want.value)
        report($sformatf("pooled_value at (%0d,%0d,%0d): got %0d, want %0d",
                         want.row, want.col, want.chan, value, want.value));
      if (row !== want.row)
        report($sformatf("out_row: got %0d, want %0d", row, want.row));
      if (col !== want.col)
        report($sformatf("out_col: got %0d, want %0d", col, want.col));
      if (chan !== want.chan)
        report($sformatf("out_channel: got %0d, want %0d", chan, want.chan));
      if (last !== want.last)
        report($sformatf("out_frame_last at (%0d,%0d,%0d): got %0b, want %0b",
                         want.row, want.col, want.chan, last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_sample;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_pooled_value;
  logic [mp2d_pkg::OUT_ROW_W-1:0] out_row;
  logic [mp2d_pkg::OUT_COL_W-1:0] out_col;
  logic [mp2d_pkg::OUT_CH_W-1:0] out_channel;
  logic out_frame_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [mp2d_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data;

  maxpool_checker sb = new();
  bit steady_feed = 1'b0;
  bit long_hold_done = 1'b0;
  int unsigned cycle_count = 0;

  max_pooling_2d_stream dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_channel      (out_channel),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Every sample transfer advances the prediction.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.take_sample(in_sample);
    end
  end

  // Every result transfer is checked against the oldest pending window.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_window(out_pooled_value, out_row, out_col, out_channel, out_frame_last);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result receiver: random stalls, one long hold-off once results flow.
  initial begin
    int ready_run, stall;
    forever begin
      if (!long_hold_done && sb.windows_checked > 300) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end
      ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (ready_run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Wait until every pending window is out, then let ignored samples drain.
  // The first edge lets the prediction of the last transfer land.
  task automatic settle();
    @(posedge clk);
    while (sb.expected_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_write(idx, data);
  endtask

  // Load a full map setting; bits above a register's width carry noise.
  task automatic program_map(int rows, int cols, int chans, int stride, int size,
                             bit poke_unused);
    logic [8:0] junk;
    settle();
    junk = 9'($urandom);
    cfg_write(mp2d_pkg::CFG_MAP_ROWS, 9'(rows));
    cfg_write(mp2d_pkg::CFG_MAP_COLS, 9'(cols));
    cfg_write(mp2d_pkg::CFG_CHANNEL_COUNT, {junk[8:7], 7'(chans)});
    cfg_write(mp2d_pkg::CFG_POOL_STRIDE, {junk[8:4], 4'(stride)});
    cfg_write(mp2d_pkg::CFG_POOL_SIZE, {junk[4:0], 4'(size)});
    if (poke_unused) begin
      cfg_write(CFG_UNUSED_BASE + 3'($urandom_range(0, 2)), junk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(logic signed [15:0] value);
    int gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stream whole frames so the position counters end at the origin.
  task automatic run_frames(int frames, bit directed);
    int total, sel;
    logic signed [15:0] s;
    total = sb.frame_items() * frames;
    for (int k = 0; k < total; k++) begin
      sel = directed ? k % 8 : $urandom_range(0, 23);
      case (sel)
        0: s = -16'sd32768;
        1: s = 16'sd32767;
        2: s = -16'sd1;
        3: s = 16'sd0;
        4: s = 16'sd1;
        5: s = 16'sh4000;
        6: s = -16'sd32767;
        7: s = -16'sd2;
        default: s = 16'($urandom);
      endcase
      send_sample(s);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int r, c, ch, st, sz;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme values over two channels, an all-negative window,
    // a window smaller than the stride with trimmed edges, and a map
    // smaller than the stride.
    program_map(2, 4, 2, 2, 2, 1'b0);
    run_frames(1, 1'b1);
    program_map(3, 3, 1, 2, 1, 1'b0);
    run_frames(1, 1'b1);
    program_map(1, 1, 1, 2, 2, 1'b0);
    run_frames(1, 1'b1);

    // Register extremes, out-of-range values saturating to the limits.
    program_map(300, 1, 1, 1, 1, 1'b0);
    run_frames(1, 1'b0);
    program_map(1, 511, 1, 1, 3, 1'b1);
    run_frames(1, 1'b0);
    program_map(2, 2, 127, 2, 2, 1'b0);
    run_frames(1, 1'b0);
    program_map(8, 8, 1, 15, 15, 1'b1);
    run_frames(1, 1'b0);
    program_map(0, 0, 0, 0, 0, 1'b1);
    run_frames(2, 1'b0);

    // Random settings, mostly small maps with a few wide ones.
    while (sb.samples_taken < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        r = $urandom_range(1, 4);
        c = $urandom_range(17, 64);
      end else begin
        r = $urandom_range(1, 12);
        c = $urandom_range(1, 12);
      end
      ch = $urandom_range(1, 4);
      st = $urandom_range(1, 4);
      sz = $urandom_range(1, st + 1);
      if ($urandom_range(0, 7) == 0) st = 0;
      if ($urandom_range(0, 7) == 0) sz = ($urandom_range(0, 1) == 0) ? 0 : 15;
      program_map(r, c, ch, st, sz, $urandom_range(0, 3) == 0);
      steady_feed = ($urandom_range(0, 3) == 0);
      run_frames($urandom_range(1, 2), 1'b0);
    end
    steady_feed = 1'b0;

    settle();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
